// ===== hw/rtl/block_decomposed_range_min_core_macros.svh =====
// Assertion macros shared by the range minimum core.
`ifndef BLOCK_DECOMPOSED_RANGE_MIN_CORE_MACROS_SVH
`define BLOCK_DECOMPOSED_RANGE_MIN_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define BDRM_ASSERT_IMPLY(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("same-cycle implication failed");
`define BDRM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("next-cycle implication failed");
`else
`define BDRM_ASSERT_IMPLY(label, clk, rst, a, b)
`define BDRM_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== hw/rtl/bdrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bdrm_pkg;
   localparam int IDX_W     = 10;
   localparam int CFG_W     = 11;
   localparam int VAL_W     = 32;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 1;
   localparam int DIV_CNT_W = $clog2(IDX_W + 1);
   localparam logic signed [VAL_W-1:0] INT_MAX = 32'sh7FFF_FFFF;

   typedef enum logic [OP_W-1:0] {
      OP_LOAD   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_SIZE    = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ELEMENT_COUNT = 1'b1;

   typedef struct packed {
      logic capture;
      logic elem_wr;
      logic div_init;
      logic div_step;
      logic load_rd;
      logic load_wr;
      logic upd_setup;
      logic qry_setup;
      logic walk;
      logic upd_wr;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   in_range;
      logic   blk_ok;
      logic   walk_done;
      logic   rsp_free;
   } status_type;
endpackage
`default_nettype wire

// ===== hw/rtl/bdrm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdrm_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   input  bdrm_pkg::status_type status,
   output bdrm_pkg::cmd_type    cmd
);
   import bdrm_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_DIV    = 10'b00_0000_0010,
      ST_QSETUP = 10'b00_0000_0100,
      ST_USETUP = 10'b00_0000_1000,
      ST_WALK   = 10'b00_0001_0000,
      ST_DRAIN  = 10'b00_0010_0000,
      ST_UWR    = 10'b00_0100_0000,
      ST_RESP   = 10'b00_1000_0000,
      ST_LRD    = 10'b01_0000_0000,
      ST_LWR    = 10'b10_0000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   last_div;
   logic                   is_write_op;

   assign req_tready  = (state_ff == ST_IDLE);
   assign last_div    = (cnt_ff == DIV_CNT_W'(IDX_W - 1));
   assign is_write_op = (status.op == OP_LOAD) || (status.op == OP_UPDATE);

   // sequence one transaction through divide, then load write-back or setup, walk and finish
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture  = req_tvalid;
            cmd.div_init = req_tvalid;
            cnt_in       = '0;
            if (req_tvalid) state_in = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cmd.elem_wr  = (cnt_ff == '0) && is_write_op && status.in_range;
            cnt_in       = cnt_ff + 1'b1;
            if (last_div) begin
               if (status.op == OP_QUERY) begin
                  state_in = ST_QSETUP;
               end else if (is_write_op && status.in_range && status.blk_ok) begin
                  state_in = (status.op == OP_LOAD) ? ST_LRD : ST_USETUP;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_QSETUP: begin
            cmd.qry_setup = 1'b1;
            state_in      = ST_WALK;
         end
         ST_USETUP: begin
            cmd.upd_setup = 1'b1;
            state_in      = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_done) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = (status.op == OP_QUERY) ? ST_RESP : ST_UWR;
         end
         ST_UWR: begin
            cmd.upd_wr = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RESP: begin
            cmd.rsp_load = status.rsp_free;
            if (status.rsp_free) state_in = ST_IDLE;
         end
         ST_LRD: begin
            cmd.load_rd = 1'b1;
            state_in    = ST_LWR;
         end
         ST_LWR: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/bdrm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bdrm_datapath #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int MAX_BLOCKS   = 64
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  csr_valid,
   input  wire  [bdrm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire  [bdrm_pkg::CFG_W-1:0]           csr_data,
   input  wire  [bdrm_pkg::OP_W-1:0]            req_op,
   input  wire  [bdrm_pkg::IDX_W-1:0]           req_index,
   input  wire  [bdrm_pkg::IDX_W-1:0]           req_right_index,
   input  wire  signed [bdrm_pkg::VAL_W-1:0]    req_value,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic signed [bdrm_pkg::VAL_W-1:0]    rsp_min_value,
   input  bdrm_pkg::cmd_type                    cmd,
   output bdrm_pkg::status_type                 status
);
   import bdrm_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int BW = $clog2(MAX_BLOCKS);
   localparam int PW = (AW + 1 > 12) ? AW + 1 : 12;

   logic signed [VAL_W-1:0] elem_mem [MAX_ELEMENTS];
   logic signed [VAL_W-1:0] bm_mem   [MAX_BLOCKS];

   logic [CFG_W-1:0]        bs_ff, cnt_ff;
   op_type                  op_ff;
   logic [IDX_W-1:0]        idx_ff, ridx_ff;
   logic signed [VAL_W-1:0] val_ff;
   logic [CFG_W-1:0]        rem_ff, rem_in;
   logic [IDX_W-1:0]        quo_ff, quo_in;
   logic [PW-1:0]           l_ff, r_ff, wb_ff;
   logic [CFG_W-1:0]        o_ff;
   logic signed [VAL_W-1:0] m_ff;
   logic                    empty_ff, elem_only_ff, pend_ff, pend_bm_ff;
   logic signed [VAL_W-1:0] el_rd_ff, bm_rd_ff;
   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_data_ff;

   logic [CFG_W-1:0]        bs_eff;
   logic [PW-1:0]           bs_w, n_eff, idx_w, ridx_w, start_w, end_w;
   logic [CFG_W:0]          trial;
   logic                    walk_done, use_blk, o_wrap;
   logic [CFG_W-1:0]        o_next;
   logic [AW-1:0]           el_addr;
   logic [BW-1:0]           bm_addr;
   logic signed [VAL_W-1:0] cand;

   assign bs_eff  = (bs_ff == '0) ? CFG_W'(1) : bs_ff;
   assign bs_w    = PW'(bs_eff);
   assign n_eff   = (PW'(cnt_ff) > PW'(MAX_ELEMENTS)) ? PW'(MAX_ELEMENTS) : PW'(cnt_ff);
   assign idx_w   = PW'(idx_ff);
   assign ridx_w  = PW'(ridx_ff);
   assign start_w = idx_w - PW'(rem_ff);
   assign end_w   = ((start_w + bs_w) > n_eff) ? n_eff : (start_w + bs_w);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bs_ff  <= CFG_W'(1);
         cnt_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_BLOCK_SIZE:    bs_ff  <= csr_data;
            CSR_ELEMENT_COUNT: cnt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // hold the accepted transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_op);
         idx_ff  <= req_index;
         ridx_ff <= req_right_index;
         val_ff  <= req_value;
      end
   end

   // restoring divide of index by block size, one quotient bit a cycle
   assign trial = {rem_ff, quo_ff[IDX_W-1]};
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = '0;
         quo_in = req_index;
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, bs_eff}) begin
            rem_in = CFG_W'(trial - {1'b0, bs_eff});
            quo_in = {quo_ff[IDX_W-2:0], 1'b1};
         end else begin
            rem_in = trial[CFG_W-1:0];
            quo_in = {quo_ff[IDX_W-2:0], 1'b0};
         end
      end
   end
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // walk step: a whole stored block minimum when aligned and covered in a query, else one element
   assign walk_done = empty_ff || (l_ff > r_ff);
   assign use_blk   = !elem_only_ff && (o_ff == '0) && ((l_ff + bs_w - 1'b1) <= r_ff)
                      && (wb_ff < PW'(MAX_BLOCKS));
   assign o_next    = o_ff + 1'b1;
   assign o_wrap    = (o_next == bs_eff);
   assign el_addr   = l_ff[AW-1:0];
   assign bm_addr   = cmd.load_rd ? quo_ff[BW-1:0] : wb_ff[BW-1:0];
   assign cand      = pend_bm_ff ? bm_rd_ff : el_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.walk && !walk_done;
      end
   end

   always_ff @(posedge clock) begin
      pend_bm_ff <= use_blk;
      if (cmd.qry_setup) begin
         l_ff         <= idx_w;
         r_ff         <= (ridx_w >= n_eff) ? n_eff - 1'b1 : ridx_w;
         o_ff         <= rem_ff;
         wb_ff        <= PW'(quo_ff);
         m_ff         <= INT_MAX;
         empty_ff     <= (n_eff == '0);
         elem_only_ff <= 1'b0;
      end else if (cmd.upd_setup) begin
         l_ff         <= start_w;
         r_ff         <= end_w - 1'b1;
         o_ff         <= '0;
         wb_ff        <= PW'(quo_ff);
         m_ff         <= INT_MAX;
         empty_ff     <= 1'b0;
         elem_only_ff <= 1'b1;
      end else begin
         if (cmd.walk && !walk_done) begin
            if (use_blk) begin
               l_ff  <= l_ff + bs_w;
               wb_ff <= wb_ff + 1'b1;
            end else begin
               l_ff  <= l_ff + 1'b1;
               o_ff  <= o_wrap ? '0 : o_next;
               wb_ff <= wb_ff + PW'(o_wrap);
            end
         end
         // fold the registered read into the running minimum
         if (pend_ff && (cand < m_ff)) m_ff <= cand;
      end
   end

   // element store
   always_ff @(posedge clock) begin
      if (cmd.elem_wr) elem_mem[idx_w[AW-1:0]] <= val_ff;
      el_rd_ff <= elem_mem[el_addr];
   end

   // block minimum store
   always_ff @(posedge clock) begin
      if (cmd.upd_wr) begin
         bm_mem[quo_ff[BW-1:0]] <= m_ff;
      end else if (cmd.load_wr && ((rem_ff == '0) || (val_ff < bm_rd_ff))) begin
         bm_mem[quo_ff[BW-1:0]] <= val_ff;
      end
      bm_rd_ff <= bm_mem[bm_addr];
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_data_ff <= m_ff;
   end

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_min_value = rsp_data_ff;

   assign status.op        = op_ff;
   assign status.in_range  = idx_w < n_eff;
   assign status.blk_ok    = PW'(quo_in) < PW'(MAX_BLOCKS);
   assign status.walk_done = walk_done;
   assign status.rsp_free  = !rsp_valid_ff || rsp_tready;
endmodule
`default_nettype wire

// ===== hw/rtl/block_decomposed_range_min_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Square-root decomposition range minimum over up to MAX_ELEMENTS signed 32-bit
// values, with one stored minimum per block of block_size elements (up to
// MAX_BLOCKS blocks). req_tuser selects load, update or query; only a query
// returns a response. Each transaction first passes through a bit-serial
// divider that splits the index into block number and offset. A load or update
// whose index or block is out of range finishes right after the divider; an
// in-range load then reads and updates its block minimum. An update or
// query then walks one memory read per cycle: the element store for the head,
// the tail and update rescans, the block minimum store for whole blocks.
// One transaction is in flight at a time; a finished response waits in an
// output register while the next request is taken.
module block_decomposed_range_min_core #(
   parameter int MAX_ELEMENTS = 1024,
   parameter int MAX_BLOCKS   = 64
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [bdrm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [bdrm_pkg::CFG_W-1:0]         csr_data,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [9:0] index, [19:10] right_index, [51:20] value, [55:52] zero
   input  wire  [55:0]                        req_tdata,
   // [1:0] op
   input  wire  [bdrm_pkg::OP_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [31:0] min_value
   output logic [31:0]                        rsp_tdata
);
   import bdrm_pkg::*;
`include "block_decomposed_range_min_core_macros.svh"

   cmd_type                 cmd;
   status_type              status;
   logic signed [VAL_W-1:0] min_value;

   assign csr_ready = 1'b1;
   assign rsp_tdata = min_value;

   bdrm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bdrm_datapath #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .MAX_BLOCKS   (MAX_BLOCKS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_op          (req_tuser),
      .req_index       (req_tdata[9:0]),
      .req_right_index (req_tdata[19:10]),
      .req_value       (req_tdata[51:20]),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_min_value   (min_value),
      .cmd             (cmd),
      .status          (status)
   );

   `BDRM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready)
   `BDRM_ASSERT_IMPLY(a_no_rsp_overwrite, clock, reset, cmd.rsp_load, status.rsp_free)
   `BDRM_ASSERT_IMPLY(a_write_in_range, clock, reset, cmd.elem_wr, status.in_range)
endmodule
`default_nettype wire

// ===== bench/block_decomposed_range_min_core_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module block_decomposed_range_min_core_tb;
   import bdrm_pkg::*;

   localparam int NUM_ELEM  = 1024;
   localparam int NUM_BLK   = 64;
   localparam int STALL_MAX = 19;
   localparam int IDLE_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 2200;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_data;
   logic                  req_tvalid;
   wire                   req_tready;
   logic [55:0]           req_tdata;
   logic [OP_W-1:0]       req_tuser;
   wire                   rsp_tvalid;
   logic                  rsp_tready;
   wire  [31:0]           rsp_tdata;

   block_decomposed_range_min_core u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   // Predictor state
   logic signed [31:0] elem_mirror [NUM_ELEM];
   logic signed [31:0] blkmin_mirror [NUM_BLK];
   logic [CFG_W-1:0]   cfg_block_size;
   logic [CFG_W-1:0]   cfg_count;
   logic signed [31:0] pending_mins [$];

   int  error_count;
   int  idle_cycles;
   bit  rsp_stall_on;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int eff_size();
      return (cfg_block_size == 0) ? 1 : int'(cfg_block_size);
   endfunction

   function automatic int eff_count();
      return (cfg_count > NUM_ELEM) ? NUM_ELEM : int'(cfg_count);
   endfunction

   // Minimum over [lo, hi] using stored block minima where a whole stored block fits
   function automatic logic signed [31:0] range_minimum(input int lo, input int hi);
      int bs;
      int l;
      logic signed [31:0] m;
      bs = eff_size();
      l = lo;
      m = INT_MAX;
      while (l <= hi && (l % bs) != 0) begin
         if (elem_mirror[l] < m) m = elem_mirror[l];
         l++;
      end
      while (l + bs - 1 <= hi) begin
         if (l / bs < NUM_BLK) begin
            if (blkmin_mirror[l / bs] < m) m = blkmin_mirror[l / bs];
         end else begin
            for (int i = l; i < l + bs; i++)
               if (elem_mirror[i] < m) m = elem_mirror[i];
         end
         l += bs;
      end
      while (l <= hi) begin
         if (elem_mirror[l] < m) m = elem_mirror[l];
         l++;
      end
      return m;
   endfunction

   // Apply one accepted transaction to the mirror, queue a query's answer
   task automatic predict_item(input op_type op, input int idx, input int ridx,
                               input logic signed [31:0] val);
      int n;
      int bs;
      int b;
      int hi;
      logic signed [31:0] m;
      n = eff_count();
      bs = eff_size();
      if (op == OP_LOAD || op == OP_UPDATE) begin
         if (idx < n) begin
            elem_mirror[idx] = val;
            b = idx / bs;
            if (b < NUM_BLK) begin
               if (op == OP_LOAD) begin
                  if ((idx % bs) == 0 || val < blkmin_mirror[b]) blkmin_mirror[b] = val;
               end else begin
                  m = INT_MAX;
                  hi = (b * bs + bs > n) ? n : b * bs + bs;
                  for (int i = b * bs; i < hi; i++)
                     if (elem_mirror[i] < m) m = elem_mirror[i];
                  blkmin_mirror[b] = m;
               end
            end
         end
      end else if (op == OP_QUERY) begin
         hi = (ridx >= n) ? n - 1 : ridx;
         if (n == 0 || idx > hi) pending_mins.push_back(INT_MAX);
         else pending_mins.push_back(range_minimum(idx, hi));
      end
   endtask

   task automatic send_item(input op_type op, input int idx, input int ridx,
                            input logic signed [31:0] val);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, STALL_MAX);
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {4'b0, val, ridx[9:0], idx[9:0]};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_item(op, idx, ridx, val);
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (pending_mins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_BLOCK_SIZE) cfg_block_size = val[CFG_W-1:0];
      else cfg_count = val[CFG_W-1:0];
      @(posedge clock);
   endtask

   function automatic logic signed [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return INT_MAX;
         1: return 32'sh8000_0000;
         2: return $urandom_range(0, 20) - 10;
         default: return $urandom();
      endcase
   endfunction

   // Configure and fill the array in index order so nothing unwritten is read
   task automatic setup_array(input int bs, input int n);
      drain();
      write_csr(CSR_BLOCK_SIZE, bs);
      write_csr(CSR_ELEMENT_COUNT, n);
      for (int i = 0; i < n; i++) send_item(OP_LOAD, i, $urandom_range(0, 1023),
                                            random_value());
   endtask

   function automatic int random_index(input int n);
      return (n == 0) ? 0 : $urandom_range(0, n - 1);
   endfunction

   task automatic test_directed();
      setup_array(3, 10);
      send_item(OP_QUERY, 0, 9, 0);
      send_item(OP_QUERY, 1, 8, 32'hFFFF_FFFF);
      send_item(OP_QUERY, 5, 2, 0);
      send_item(OP_QUERY, 4, 1023, 0);
      send_item(OP_QUERY, 1023, 1023, 0);
      send_item(OP_UPDATE, 4, 0, 32'sh8000_0000);
      send_item(OP_QUERY, 0, 9, 0);
      send_item(OP_UPDATE, 4, 0, INT_MAX);
      send_item(OP_QUERY, 3, 5, 0);
      send_item(OP_LOAD, 1023, 0, -5);
      send_item(OP_UPDATE, 10, 0, -5);
      send_item(OP_NONE, 0, 9, -7);
      send_item(OP_QUERY, 9, 9, 0);
      // Zero block size behaves as one
      setup_array(0, 10);
      send_item(OP_UPDATE, 2, 0, -3);
      send_item(OP_QUERY, 0, 9, 0);
      // Empty array
      drain();
      write_csr(CSR_ELEMENT_COUNT, 0);
      send_item(OP_QUERY, 0, 0, 0);
   endtask

   // Blocks beyond the stored minima, a large block and a count above capacity
   task automatic test_wide_blocks();
      setup_array(1, 100);
      for (int k = 0; k < 5; k++) send_item(OP_QUERY, random_index(100), 1023, 0);
      setup_array(40, 120);
      send_item(OP_QUERY, 0, 1023, 0);
      send_item(OP_UPDATE, 119, 0, 32'sh8000_0000);
      send_item(OP_QUERY, 0, 1023, 0);
      send_item(OP_QUERY, 500, 1023, 0);
      // fill only the top elements, whose blocks keep no minimum
      drain();
      write_csr(CSR_BLOCK_SIZE, 8);
      write_csr(CSR_ELEMENT_COUNT, 2047);
      for (int i = 1000; i < NUM_ELEM; i++) send_item(OP_LOAD, i, 0, random_value());
      send_item(OP_QUERY, 1000, 1023, 0);
      send_item(OP_QUERY, 1003, 1023, 0);
      send_item(OP_UPDATE, 1000, 0, -1);
      send_item(OP_QUERY, 1000, 1019, 0);
      send_item(OP_QUERY, 999, 2, 0);
   endtask

   task automatic test_random(input int rounds);
      int n;
      int bs;
      int r;
      for (int p = 0; p < rounds; p++) begin
         n = $urandom_range(1, 40);
         bs = $urandom_range(0, 3) == 0 ? $urandom_range(0, 12) : $urandom_range(1, 7);
         setup_array(bs, n);
         for (int k = 0; k < 30; k++) begin
            r = $urandom_range(0, 9);
            if (r < 5)
               send_item(OP_QUERY, $urandom_range(0, 5) == 0 ? $urandom_range(0, 1023)
                         : random_index(n), $urandom_range(0, 3) == 0 ?
                         $urandom_range(0, 1023) : random_index(n), random_value());
            else if (r < 9)
               send_item(OP_UPDATE, $urandom_range(0, 7) == 0 ? $urandom_range(0, 1023)
                         : random_index(n), $urandom(), random_value());
            else
               send_item($urandom_range(0, 1) ? OP_NONE : OP_LOAD,
                         $urandom_range(n, 1023), $urandom(), random_value());
         end
      end
   endtask

   // Check each accepted response against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_mins.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 32'h0);
         end else begin
            if (rsp_tdata !== pending_mins[0])
               report_mismatch("min_value", rsp_tdata, pending_mins[0]);
            void'(pending_mins.pop_front());
         end
      end
   end

   // Random receiver stalls, with calm stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if ($urandom_range(0, 199) == 0) rsp_stall_on = ~rsp_stall_on;
         rsp_tready <= rsp_stall_on ? ($urandom_range(0, 19) == 0) : 1'b1;
      end
   end

   // Watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("block_decomposed_range_min_core regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_NONE;
      error_count = 0;
      cfg_block_size = 1;
      cfg_count = 0;
      for (int i = 0; i < NUM_ELEM; i++) elem_mirror[i] = 0;
      for (int i = 0; i < NUM_BLK; i++) blkmin_mirror[i] = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(4);
      test_wide_blocks();
      test_random(2);
      drain();
      if (error_count == 0 && pending_mins.size() == 0) begin
         $display("block_decomposed_range_min_core regression: pass");
      end else begin
         $display("block_decomposed_range_min_core regression: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
